@@ design/bfstpd_pkg.sv @@
package bfstpd_pkg;

	localparam int MAX_ATOMS_DEF  = 4096;
	localparam int COORD_BITS_DEF = 32;

	localparam int ATOM_CNT_W = 13;
	localparam int INDEX_W    = 12;
	localparam int KIDS_W     = 2;
	localparam int OUT_W      = 32;

	localparam logic [ATOM_CNT_W-1:0] ATOM_COUNT_RST = 13'd4096;

	localparam logic [KIDS_W-1:0] KIDS_ONE = 2'd1;
	localparam logic [KIDS_W-1:0] KIDS_TWO = 2'd2;
	localparam logic [KIDS_W-1:0] KIDS_BAD = 2'd3;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_BAD_KIDS = 2'd1,
		ST_RANGE    = 2'd2,
		ST_EMPTY    = 2'd3
	} status_t;

endpackage

@@ design/bfstpd_ram.sv @@
module bfstpd_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

@@ design/bfs_tree_parent_prediction_decoder.sv @@
// Rebuilds atom positions from tree nodes that arrive in breadth-first order. Each accepted
// transaction pops its parent from a queue memory (or uses the origin for the root of a frame),
// reads the parent's position from the position memory, adds the residuals modulo
// 2^COORD_BITS, writes the new position back and pushes its own index once per child. A node
// is taken every cycle unless the output stalls or the last node queued two children, as
// the queue memory has one write port. Results are registered in s1, s2 and the output
// register. Both memories come out of reset with undefined contents and need no clearing
// pass; a frame starts with a node that has first_node set.
module bfs_tree_parent_prediction_decoder
	import bfstpd_pkg::*;
#(
	parameter int MAX_ATOMS  = MAX_ATOMS_DEF,
	parameter int COORD_BITS = COORD_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_write,
	input  logic [ATOM_CNT_W-1:0] cfg_data,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic                  first_node,
	input  logic [KIDS_W-1:0]     child_count,
	input  logic [INDEX_W-1:0]    atom_index,
	input  logic signed [31:0]    residual_x,
	input  logic signed [31:0]    residual_y,
	input  logic signed [31:0]    residual_z,
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic [INDEX_W-1:0]    out_index,
	output logic [OUT_W-1:0]      pos_x,
	output logic [OUT_W-1:0]      pos_y,
	output logic [OUT_W-1:0]      pos_z,
	output logic [1:0]            status,
	output logic                  frame_done
);

	localparam int AW = $clog2(MAX_ATOMS);
	localparam int FW = $clog2(MAX_ATOMS + 1);
	localparam int CB = COORD_BITS;

	function automatic logic [AW-1:0] advance(input logic [AW-1:0] p);
		begin
			advance = (p == AW'(MAX_ATOMS - 1)) ? '0 : p + 1'b1;
		end
	endfunction

	logic [ATOM_CNT_W-1:0] atom_count_q;
	logic [AW-1:0]         head_q;
	logic [AW-1:0]         tail_q;
	logic [FW-1:0]         fill_q;
	logic                  root_q;
	logic                  push2_q;
	logic [AW-1:0]         push2_addr_q;
	logic [AW-1:0]         push2_data_q;

	logic                  accept;
	logic [AW-1:0]         head_e;
	logic [AW-1:0]         tail_e;
	logic [FW-1:0]         fill_e;
	logic                  root_e;
	status_t               st;
	logic                  ok;
	logic                  pop;
	logic [FW-1:0]         fill_p;
	logic                  push1;
	logic                  push2;
	logic [AW-1:0]         tail1;
	logic [AW-1:0]         head_n;
	logic [AW-1:0]         tail_n;
	logic [FW-1:0]         fill_n;
	logic                  root_n;
	logic                  done_n;
	logic [AW-1:0]         idx_aw;

	logic                  valid_s1;
	logic                  ok_s1;
	logic                  root_s1;
	status_t               st_s1;
	logic                  done_s1;
	logic [INDEX_W-1:0]    idx_s1;
	logic [CB-1:0]         res_x_s1;
	logic [CB-1:0]         res_y_s1;
	logic [CB-1:0]         res_z_s1;

	logic                  valid_s2;
	logic                  ok_s2;
	logic                  root_s2;
	status_t               st_s2;
	logic                  done_s2;
	logic [INDEX_W-1:0]    idx_s2;
	logic [CB-1:0]         res_x_s2;
	logic [CB-1:0]         res_y_s2;
	logic [CB-1:0]         res_z_s2;
	logic                  fwd_hit_s2;
	logic [3*CB-1:0]       fwd_pos_s2;

	logic                  out_valid_q;
	logic [INDEX_W-1:0]    out_index_q;
	logic [OUT_W-1:0]      pos_x_q;
	logic [OUT_W-1:0]      pos_y_q;
	logic [OUT_W-1:0]      pos_z_q;
	status_t               status_q;
	logic                  done_q;

	logic                  move_out;
	logic                  move_s1;
	logic                  q_we;
	logic [AW-1:0]         q_waddr;
	logic [AW-1:0]         q_wdata;
	logic [AW-1:0]         q_rdata;
	logic                  p_re;
	logic                  p_we;
	logic [3*CB-1:0]       p_rdata;
	logic [3*CB-1:0]       pred;
	logic [3*CB-1:0]       sum_s2;

	assign move_out = valid_s2 && (!out_valid_q || !out_stall);
	assign move_s1  = valid_s1 && (!valid_s2 || move_out);
	assign in_stall = push2_q || (valid_s1 && !move_s1);
	assign accept   = in_valid && !in_stall;
	assign idx_aw   = AW'(atom_index);

	always_comb begin
		head_e = first_node ? '0 : head_q;
		tail_e = first_node ? '0 : tail_q;
		fill_e = first_node ? '0 : fill_q;
		root_e = first_node ? 1'b1 : root_q;

		if (!root_e && fill_e == '0) begin
			st = ST_EMPTY;
		end else if (child_count == KIDS_BAD) begin
			st = ST_BAD_KIDS;
		end else if (({1'b0, atom_index} >= atom_count_q) ||
				(32'(atom_index) >= 32'(MAX_ATOMS))) begin
			st = ST_RANGE;
		end else begin
			st = ST_OK;
		end
		ok = (st == ST_OK);

		pop    = ok && !root_e;
		fill_p = pop ? fill_e - 1'b1 : fill_e;
		push1  = ok && (child_count == KIDS_ONE || child_count == KIDS_TWO) &&
			(fill_p < FW'(MAX_ATOMS));
		push2  = push1 && (child_count == KIDS_TWO) && (fill_p < FW'(MAX_ATOMS - 1));
		tail1  = advance(tail_e);

		head_n = pop ? advance(head_e) : head_e;
		tail_n = push2 ? advance(tail1) : (push1 ? tail1 : tail_e);
		fill_n = fill_p + FW'(push1) + FW'(push2);
		root_n = ok ? 1'b0 : root_e;
		done_n = ok ? (fill_n == '0) : (st == ST_EMPTY);
	end

	always_comb begin
		if (push2_q) begin
			q_we    = 1'b1;
			q_waddr = push2_addr_q;
			q_wdata = push2_data_q;
		end else begin
			q_we    = accept && push1;
			q_waddr = tail_e;
			q_wdata = idx_aw;
		end
	end

	bfstpd_ram #(
		.WIDTH(AW),
		.DEPTH(MAX_ATOMS)
	) u_queue_ram (
		.clk  (clk),
		.we   (q_we),
		.waddr(q_waddr),
		.wdata(q_wdata),
		.re   (accept && pop),
		.raddr(head_e),
		.rdata(q_rdata)
	);

	assign p_re = move_s1 && ok_s1 && !root_s1;
	assign p_we = move_out && ok_s2;

	bfstpd_ram #(
		.WIDTH(3 * CB),
		.DEPTH(MAX_ATOMS)
	) u_pos_ram (
		.clk  (clk),
		.we   (p_we),
		.waddr(AW'(idx_s2)),
		.wdata(sum_s2),
		.re   (p_re),
		.raddr(q_rdata),
		.rdata(p_rdata)
	);

	always_comb begin
		if (root_s2) begin
			pred = '0;
		end else if (fwd_hit_s2) begin
			pred = fwd_pos_s2;
		end else begin
			pred = p_rdata;
		end
		sum_s2[CB-1:0]      = pred[CB-1:0] + res_x_s2;
		sum_s2[2*CB-1:CB]   = pred[2*CB-1:CB] + res_y_s2;
		sum_s2[3*CB-1:2*CB] = pred[3*CB-1:2*CB] + res_z_s2;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			atom_count_q <= ATOM_COUNT_RST;
			head_q       <= '0;
			tail_q       <= '0;
			fill_q       <= '0;
			root_q       <= 1'b1;
			push2_q      <= 1'b0;
			valid_s1     <= 1'b0;
			valid_s2     <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if (cfg_write) begin
				atom_count_q <= cfg_data;
			end
			push2_q <= accept && push2;
			if (accept) begin
				head_q <= head_n;
				tail_q <= tail_n;
				fill_q <= fill_n;
				root_q <= root_n;
			end
			if (accept) begin
				valid_s1 <= 1'b1;
			end else if (move_s1) begin
				valid_s1 <= 1'b0;
			end
			if (move_s1) begin
				valid_s2 <= 1'b1;
			end else if (move_out) begin
				valid_s2 <= 1'b0;
			end
			if (move_out) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			push2_addr_q <= tail1;
			push2_data_q <= idx_aw;
			ok_s1        <= ok;
			root_s1      <= root_e;
			st_s1        <= st;
			done_s1      <= done_n;
			idx_s1       <= atom_index;
			res_x_s1     <= residual_x[CB-1:0];
			res_y_s1     <= residual_y[CB-1:0];
			res_z_s1     <= residual_z[CB-1:0];
		end
		if (move_s1) begin
			ok_s2      <= ok_s1;
			root_s2    <= root_s1;
			st_s2      <= st_s1;
			done_s2    <= done_s1;
			idx_s2     <= idx_s1;
			res_x_s2   <= res_x_s1;
			res_y_s2   <= res_y_s1;
			res_z_s2   <= res_z_s1;
			fwd_hit_s2 <= valid_s2 && ok_s2 && (AW'(idx_s2) == q_rdata);
			fwd_pos_s2 <= sum_s2;
		end
		if (move_out) begin
			out_index_q <= idx_s2;
			pos_x_q     <= ok_s2 ? OUT_W'(sum_s2[CB-1:0]) : '0;
			pos_y_q     <= ok_s2 ? OUT_W'(sum_s2[2*CB-1:CB]) : '0;
			pos_z_q     <= ok_s2 ? OUT_W'(sum_s2[3*CB-1:2*CB]) : '0;
			status_q    <= st_s2;
			done_q      <= done_s2;
		end
	end

	assign out_valid  = out_valid_q;
	assign out_index  = out_index_q;
	assign pos_x      = pos_x_q;
	assign pos_y      = pos_y_q;
	assign pos_z      = pos_z_q;
	assign status     = status_q;
	assign frame_done = done_q;

endmodule

@@ design/bfstpd_checker.sv @@
module bfstpd_checker
	import bfstpd_pkg::*;
(
	input logic               clk,
	input logic               arst_n,
	input logic               out_valid,
	input logic               out_stall,
	input logic [INDEX_W-1:0] out_index,
	input logic [OUT_W-1:0]   pos_x,
	input logic [OUT_W-1:0]   pos_y,
	input logic [OUT_W-1:0]   pos_z,
	input logic [1:0]         status,
	input logic               frame_done
);

	// A stalled result transaction stays offered with the same payload.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_index) && $stable(pos_x) &&
			$stable(pos_y) && $stable(pos_z) && $stable(status) && $stable(frame_done))
		else $error("result changed while stalled");

	// A rejected node reports the origin as its position.
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != ST_OK |-> pos_x == '0 && pos_y == '0 && pos_z == '0)
		else $error("rejected node carries a position");

	// An empty queue always means the frame is done.
	a_empty_done: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == ST_EMPTY |-> frame_done)
		else $error("empty queue without frame completion");

	// Other rejections never report the frame as done.
	a_bad_open: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status == ST_BAD_KIDS || status == ST_RANGE) |-> !frame_done)
		else $error("rejected node reports frame completion");

endmodule

bind bfs_tree_parent_prediction_decoder bfstpd_checker u_bfstpd_checker (.*);
